FILE: hw/rtl/mmo_pkg.sv
// Shared types, constants and codes for the multi-motor overload monitor.
// Used by mmo_judge, the top level and the bench; depends on nothing.
package mmo_pkg;

  localparam int MOTORS    = 6;
  localparam int MOT_AW    = $clog2(MOTORS);
  localparam int PWM_W     = 10;
  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;
  localparam logic [7:0] OVERCURRENT_BIT = 8'h40;

  typedef enum logic [1:0] {
    FUNC_START     = 2'd0,
    FUNC_BASELINE  = 2'd1,
    FUNC_MONITOR   = 2'd2,
    FUNC_THRESHOLD = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_STATUS = 2'd1,
    CAUSE_PWM    = 2'd2
  } cause_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_DELTA        = 3'd0,
    REG_BASE_HITS_NEEDED  = 3'd1,
    REG_OTHER_HITS_NEEDED = 3'd2,
    REG_DEMO_MODE         = 3'd3,
    REG_BASE_MOTOR        = 3'd4,
    REG_STATUS_CHECK_ON   = 3'd5,
    REG_STATUS_FAULT_MASK = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [PWM_W-1:0] base_delta;
    logic [CNT_W-1:0] base_hits_needed;
    logic [CNT_W-1:0] other_hits_needed;
    logic             demo_mode;
    logic [2:0]       base_motor;
    logic             status_check_on;
    logic [7:0]       status_fault_mask;
  } cfg_t;

  typedef struct packed {
    func_t            func;
    logic [2:0]       motor;
    logic [PWM_W-1:0] pwm;
    logic             read_ok;
    logic             status_ok;
    logic [7:0]       status_bits;
    logic [7:0]       detail_bits;
    logic [PWM_W-1:0] threshold_value;
  } item_t;

  // Per-motor move state kept in the state memory.
  typedef struct packed {
    logic [PWM_W-1:0] baseline;
    logic [PWM_W-1:0] peak;
    logic [CNT_W-1:0] pwm_cnt;
    logic [CNT_W-1:0] status_cnt;
  } entry_t;

  typedef struct packed {
    logic       baseline_ready;
    logic       trip_flag;
    cause_t     trip_reason;
    logic [2:0] trip_index;
  } glob_t;

  typedef struct packed {
    logic             tripped;
    logic             trip_now;
    cause_t           trip_cause;
    logic [2:0]       trip_motor;
    logic             pwm_high;
    logic             status_fault;
    logic [PWM_W-1:0] peak_pwm;
  } result_t;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    bump = (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
  endfunction

endpackage

FILE: hw/rtl/mmo_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Stands alone; no package needed.
module mmo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/mmo_judge.sv
// Per-item decision logic: judges a sample, updates the motor entry and trip state.
// Depends on mmo_pkg.
module mmo_judge (
  input  mmo_pkg::item_t               item,
  input  mmo_pkg::cfg_t                cfg,
  input  mmo_pkg::entry_t              entry,
  input  logic [mmo_pkg::PWM_W-1:0]    thr,
  input  mmo_pkg::glob_t               glob,
  output mmo_pkg::entry_t              entry_nxt,
  output mmo_pkg::glob_t               glob_nxt,
  output mmo_pkg::result_t             res
);

  logic                       motor_ok;
  logic                       is_base;
  logic [mmo_pkg::CNT_W-1:0]  needed;
  logic                       fault;
  logic                       high;
  logic [mmo_pkg::PWM_W:0]    base_sum;
  logic                       now;
  logic                       st_trip;
  logic [mmo_pkg::CNT_W-1:0]  st_cnt;
  logic [mmo_pkg::CNT_W-1:0]  pw_cnt;

  always_comb begin
    motor_ok = {1'b0, item.motor} < 4'(mmo_pkg::MOTORS);
    is_base  = item.motor == cfg.base_motor;
    needed   = is_base ? cfg.base_hits_needed : cfg.other_hits_needed;
    base_sum = {1'b0, entry.baseline} + {1'b0, cfg.base_delta};
    fault    = cfg.status_check_on && item.status_ok &&
               (((item.status_bits & cfg.status_fault_mask) != 8'd0) ||
                ((item.detail_bits & mmo_pkg::OVERCURRENT_BIT) != 8'd0));
    high     = item.read_ok &&
               (((thr != '0) && (item.pwm > thr)) ||
                (is_base && cfg.demo_mode && glob.baseline_ready &&
                 ({1'b0, item.pwm} >= base_sum) && (item.pwm > thr)));

    entry_nxt = entry;
    glob_nxt  = glob;
    now       = 1'b0;
    st_trip   = 1'b0;
    st_cnt    = mmo_pkg::bump(entry.status_cnt);
    pw_cnt    = mmo_pkg::bump(entry.pwm_cnt);

    case (item.func)
      mmo_pkg::FUNC_START: begin
        entry_nxt = '0;
        glob_nxt  = '0;
      end
      mmo_pkg::FUNC_BASELINE: begin
        if (motor_ok) begin
          if (item.read_ok) begin
            entry_nxt.baseline = item.pwm;
          end
          glob_nxt.baseline_ready = 1'b1;
        end
      end
      mmo_pkg::FUNC_MONITOR: begin
        if (motor_ok && !glob.trip_flag) begin
          if (item.read_ok && (item.pwm > entry.peak)) begin
            entry_nxt.peak = item.pwm;
          end
          if (fault) begin
            entry_nxt.status_cnt = st_cnt;
            st_trip = st_cnt >= needed;
          end else begin
            entry_nxt.status_cnt = '0;
          end
          if (st_trip) begin
            now = 1'b1;
            glob_nxt.trip_flag   = 1'b1;
            glob_nxt.trip_reason = mmo_pkg::CAUSE_STATUS;
            glob_nxt.trip_index  = item.motor;
          end else if (item.read_ok) begin
            if (high) begin
              entry_nxt.pwm_cnt = pw_cnt;
              if (pw_cnt >= needed) begin
                now = 1'b1;
                glob_nxt.trip_flag   = 1'b1;
                glob_nxt.trip_reason = mmo_pkg::CAUSE_PWM;
                glob_nxt.trip_index  = item.motor;
              end
            end else begin
              entry_nxt.pwm_cnt = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase

    res.tripped      = glob_nxt.trip_flag;
    res.trip_now     = now;
    res.trip_cause   = glob_nxt.trip_reason;
    res.trip_motor   = glob_nxt.trip_index;
    res.pwm_high     = motor_ok && (item.func == mmo_pkg::FUNC_MONITOR) && high;
    res.status_fault = motor_ok && (item.func == mmo_pkg::FUNC_MONITOR) && fault;
    res.peak_pwm     = (motor_ok && (item.func != mmo_pkg::FUNC_START)) ?
                       entry_nxt.peak : '0;
  end

endmodule

FILE: hw/rtl/multi_motor_overload_monitor_unit.sv
// Top level of the multi-motor overload monitor: stream ports, state memories,
// forwarding and output register. Depends on mmo_pkg, mmo_ram and mmo_judge.
//
// The block takes one item per clock while not stalled and returns one result item
// for each, via the stage-one and output registers. Per-motor state lives in two
// small synchronous memories read in the cycle of acceptance; the item is judged
// and, once the output is free, its entry is written back and the output register
// loaded. Per-memory one-entry forwarding registers cover back-to-back items on
// the same motor. A start item clears the move state of all motors at once through
// per-motor valid bits; thresholds survive it and are cleared only by reset.
// Configuration writes take effect at once and belong to idle periods.
module multi_motor_overload_monitor_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: motor[2:0], pwm[12:3], read_ok[13], status_ok[14], status_bits[22:15],
  //        detail_bits[30:23], threshold_value[40:31], zero fill[47:41]
  input  logic [47:0]                     in_tdata,
  // tuser: func[1:0]
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata: tripped[0], trip_now[1], trip_cause[3:2], trip_motor[6:4], pwm_high[7],
  //        status_fault[8], peak_pwm[18:9], zero fill[23:19]
  output logic [23:0]                     out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [mmo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mmo_pkg::CFG_DAT_W-1:0]   cfg_wdata
);

  localparam int EW = $bits(mmo_pkg::entry_t);

  mmo_pkg::cfg_t    cfg_r;
  mmo_pkg::glob_t   glob_r;
  mmo_pkg::glob_t   glob_nxt;
  mmo_pkg::item_t   in_item;
  mmo_pkg::item_t   s1_item_r;
  logic             s1_valid_r;
  logic             s1_fire;
  logic             in_fire;
  logic             out_free;
  logic             s1_motor_ok;
  logic [mmo_pkg::MOT_AW-1:0] s1_addr;

  logic [mmo_pkg::MOTORS-1:0] ent_valid_r;
  logic [mmo_pkg::MOTORS-1:0] thr_valid_r;
  logic                       ent_fwd_valid_r;
  logic [mmo_pkg::MOT_AW-1:0] ent_fwd_addr_r;
  mmo_pkg::entry_t            ent_fwd_data_r;
  logic                       thr_fwd_valid_r;
  logic [mmo_pkg::MOT_AW-1:0] thr_fwd_addr_r;
  logic [mmo_pkg::PWM_W-1:0]  thr_fwd_data_r;

  logic [EW-1:0]              ent_rdata;
  logic [mmo_pkg::PWM_W-1:0]  thr_rdata;
  mmo_pkg::entry_t            ent_cur;
  mmo_pkg::entry_t            ent_nxt;
  logic [mmo_pkg::PWM_W-1:0]  thr_cur;
  logic                       ent_we;
  logic                       thr_we;
  mmo_pkg::result_t           res;
  mmo_pkg::result_t           out_r;
  logic                       out_valid_r;

  assign in_item.func            = mmo_pkg::func_t'(in_tuser);
  assign in_item.motor           = in_tdata[2:0];
  assign in_item.pwm             = in_tdata[12:3];
  assign in_item.read_ok         = in_tdata[13];
  assign in_item.status_ok       = in_tdata[14];
  assign in_item.status_bits     = in_tdata[22:15];
  assign in_item.detail_bits     = in_tdata[30:23];
  assign in_item.threshold_value = in_tdata[40:31];

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_motor_ok = {1'b0, s1_item_r.motor} < 4'(mmo_pkg::MOTORS);
  assign s1_addr     = s1_item_r.motor[mmo_pkg::MOT_AW-1:0];

  always_comb begin
    if (ent_fwd_valid_r && (ent_fwd_addr_r == s1_addr)) begin
      ent_cur = ent_fwd_data_r;
    end else if (s1_motor_ok && ent_valid_r[s1_addr]) begin
      ent_cur = mmo_pkg::entry_t'(ent_rdata);
    end else begin
      ent_cur = '0;
    end
    if (thr_fwd_valid_r && (thr_fwd_addr_r == s1_addr)) begin
      thr_cur = thr_fwd_data_r;
    end else if (s1_motor_ok && thr_valid_r[s1_addr]) begin
      thr_cur = thr_rdata;
    end else begin
      thr_cur = '0;
    end
  end

  assign ent_we = s1_fire && s1_motor_ok &&
                  ((s1_item_r.func == mmo_pkg::FUNC_BASELINE) ||
                   (s1_item_r.func == mmo_pkg::FUNC_MONITOR));
  assign thr_we = s1_fire && s1_motor_ok && (s1_item_r.func == mmo_pkg::FUNC_THRESHOLD);

  mmo_ram #(.WIDTH(EW), .DEPTH(mmo_pkg::MOTORS)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (s1_addr),
    .wdata (ent_nxt),
    .re    (in_fire),
    .raddr (in_item.motor[mmo_pkg::MOT_AW-1:0]),
    .rdata (ent_rdata)
  );

  mmo_ram #(.WIDTH(mmo_pkg::PWM_W), .DEPTH(mmo_pkg::MOTORS)) u_thr_ram (
    .clk   (clk),
    .we    (thr_we),
    .waddr (s1_addr),
    .wdata (s1_item_r.threshold_value),
    .re    (in_fire),
    .raddr (in_item.motor[mmo_pkg::MOT_AW-1:0]),
    .rdata (thr_rdata)
  );

  mmo_judge u_judge (
    .item      (s1_item_r),
    .cfg       (cfg_r),
    .entry     (ent_cur),
    .thr       (thr_cur),
    .glob      (glob_r),
    .entry_nxt (ent_nxt),
    .glob_nxt  (glob_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_delta        <= '0;
      cfg_r.base_hits_needed  <= 8'd3;
      cfg_r.other_hits_needed <= 8'd3;
      cfg_r.demo_mode         <= 1'b0;
      cfg_r.base_motor        <= 3'd0;
      cfg_r.status_check_on   <= 1'b1;
      cfg_r.status_fault_mask <= 8'h50;
    end else if (cfg_wr_en) begin
      case (mmo_pkg::cfg_reg_t'(cfg_index))
        mmo_pkg::REG_BASE_DELTA:        cfg_r.base_delta        <= cfg_wdata;
        mmo_pkg::REG_BASE_HITS_NEEDED:  cfg_r.base_hits_needed  <= cfg_wdata[7:0];
        mmo_pkg::REG_OTHER_HITS_NEEDED: cfg_r.other_hits_needed <= cfg_wdata[7:0];
        mmo_pkg::REG_DEMO_MODE:         cfg_r.demo_mode         <= cfg_wdata[0];
        mmo_pkg::REG_BASE_MOTOR:        cfg_r.base_motor        <= cfg_wdata[2:0];
        mmo_pkg::REG_STATUS_CHECK_ON:   cfg_r.status_check_on   <= cfg_wdata[0];
        mmo_pkg::REG_STATUS_FAULT_MASK: cfg_r.status_fault_mask <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      glob_r          <= '0;
      ent_valid_r     <= '0;
      thr_valid_r     <= '0;
      ent_fwd_valid_r <= 1'b0;
      thr_fwd_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        glob_r <= glob_nxt;
        if (s1_item_r.func == mmo_pkg::FUNC_START) begin
          ent_valid_r     <= '0;
          ent_fwd_valid_r <= 1'b0;
        end
      end
      if (ent_we) begin
        ent_valid_r[s1_addr] <= 1'b1;
        ent_fwd_valid_r      <= 1'b1;
      end
      if (thr_we) begin
        thr_valid_r[s1_addr] <= 1'b1;
        thr_fwd_valid_r      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
    if (s1_fire) begin
      out_r <= res;
    end
    if (ent_we) begin
      ent_fwd_addr_r <= s1_addr;
      ent_fwd_data_r <= ent_nxt;
    end
    if (thr_we) begin
      thr_fwd_addr_r <= s1_addr;
      thr_fwd_data_r <= s1_item_r.threshold_value;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_r.peak_pwm, out_r.status_fault, out_r.pwm_high,
                       out_r.trip_motor, out_r.trip_cause, out_r.trip_now, out_r.tripped};

  a_now_implies_tripped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.trip_now |-> out_r.tripped)
    else $error("trip_now without sticky trip");

  a_trip_rises_on_monitor: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(glob_r.trip_flag) |-> $past(s1_fire && (s1_item_r.func == mmo_pkg::FUNC_MONITOR)))
    else $error("trip flag set by a non-monitor item");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a full pipeline");

  a_start_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_item_r.func == mmo_pkg::FUNC_START) |=>
      (ent_valid_r == '0) && !glob_r.trip_flag && !glob_r.baseline_ready)
    else $error("start item did not clear move state");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for multi_motor_overload_monitor_unit: a bursty item driver,
// a stalling result receiver and an in-bench predictor of trips, hits and peaks.
// Depends on mmo_pkg and the RTL of the unit.
module tb_top;
  import mmo_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 300;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [47:0]          in_tdata   = '0;
  logic [1:0]           in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata  = '0;

  multi_motor_overload_monitor_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Predicted state of the monitor.
  cfg_t             mcfg;
  logic [PWM_W-1:0] thr_tab  [MOTORS];
  logic [PWM_W-1:0] base_tab [MOTORS];
  logic [PWM_W-1:0] peak_tab [MOTORS];
  logic [CNT_W-1:0] pwm_cnt  [MOTORS];
  logic [CNT_W-1:0] st_cnt   [MOTORS];
  logic             bl_ready;
  logic             trip;
  cause_t           reason;
  logic [2:0]       trip_m;

  item_t   pend_q [$];
  result_t exp_q  [$];
  item_t   drv_item;
  logic    in_taken = 1'b0;
  int      fails    = 0;
  int      cycles   = 0;
  int      gen_cnt  = 0;
  int      gen_thr  [MOTORS] = '{default: 0};
  int      gen_base [MOTORS] = '{default: 0};
  int      hold_req = 0;
  int      hold_seen = 0;
  int      hold_left = 0;
  int      rx_mode = 0;
  int      rx_left = 0;
  int      burst_left = 1;
  int      gap_left = 0;

  function automatic logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] c);
    return (c == 8'hFF) ? c : c + 8'd1;
  endfunction

  function automatic void clear_move_state();
    for (int k = 0; k < MOTORS; k++) begin
      base_tab[k] = '0;
      peak_tab[k] = '0;
      pwm_cnt[k]  = '0;
      st_cnt[k]   = '0;
    end
    bl_ready = 1'b0;
    trip     = 1'b0;
    reason   = CAUSE_NONE;
    trip_m   = '0;
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t          r;
    logic [PWM_W-1:0] thr;
    logic [CNT_W-1:0] need;
    logic [PWM_W:0]   lim;
    logic             in_range, is_base, hi, flt, now;
    r        = '0;
    hi       = 1'b0;
    flt      = 1'b0;
    now      = 1'b0;
    in_range = (it.motor < MOTORS);
    if (it.func == FUNC_START) begin
      clear_move_state();
    end else if (in_range && it.func == FUNC_BASELINE) begin
      if (it.read_ok) base_tab[it.motor] = it.pwm;
      bl_ready = 1'b1;
    end else if (in_range && it.func == FUNC_THRESHOLD) begin
      thr_tab[it.motor] = it.threshold_value;
    end else if (in_range && it.func == FUNC_MONITOR) begin
      thr     = thr_tab[it.motor];
      is_base = (it.motor == mcfg.base_motor);
      need    = is_base ? mcfg.base_hits_needed : mcfg.other_hits_needed;
      lim     = {1'b0, base_tab[it.motor]} + {1'b0, mcfg.base_delta};
      flt = mcfg.status_check_on && it.status_ok &&
            (((it.status_bits & mcfg.status_fault_mask) != 0) ||
             ((it.detail_bits & OVERCURRENT_BIT) != 0));
      if (it.read_ok) begin
        if (thr != 0 && it.pwm > thr) hi = 1'b1;
        if (is_base && mcfg.demo_mode && bl_ready && {1'b0, it.pwm} >= lim && it.pwm > thr)
          hi = 1'b1;
      end
      if (!trip) begin
        if (it.read_ok && it.pwm > peak_tab[it.motor]) peak_tab[it.motor] = it.pwm;
        if (flt) begin
          st_cnt[it.motor] = count_up(st_cnt[it.motor]);
          if (st_cnt[it.motor] >= need) begin
            trip   = 1'b1;
            reason = CAUSE_STATUS;
            trip_m = it.motor;
            now    = 1'b1;
          end
        end else begin
          st_cnt[it.motor] = '0;
        end
        if (!now && it.read_ok) begin
          if (hi) begin
            pwm_cnt[it.motor] = count_up(pwm_cnt[it.motor]);
            if (pwm_cnt[it.motor] >= need) begin
              trip   = 1'b1;
              reason = CAUSE_PWM;
              trip_m = it.motor;
              now    = 1'b1;
            end
          end else begin
            pwm_cnt[it.motor] = '0;
          end
        end
      end
    end
    if (in_range) r.peak_pwm = peak_tab[it.motor];
    r.tripped      = trip;
    r.trip_now     = now;
    r.trip_cause   = reason;
    r.trip_motor   = trip_m;
    r.pwm_high     = hi;
    r.status_fault = flt;
    return r;
  endfunction

  // Stimulus helpers.
  function automatic void add_item(func_t f, int m, int p, bit rok, bit sok, int sb, int db,
                                   int thr);
    item_t it;
    it.func            = f;
    it.motor           = m[2:0];
    it.pwm             = p[PWM_W-1:0];
    it.read_ok         = rok;
    it.status_ok       = sok;
    it.status_bits     = sb[7:0];
    it.detail_bits     = db[7:0];
    it.threshold_value = thr[PWM_W-1:0];
    if (f == FUNC_START) gen_base = '{default: 0};
    if (f == FUNC_THRESHOLD && it.motor < MOTORS) gen_thr[it.motor] = it.threshold_value;
    if (f == FUNC_BASELINE && it.motor < MOTORS && rok) gen_base[it.motor] = it.pwm;
    pend_q.push_back(it);
    gen_cnt++;
  endfunction

  function automatic void add_rand(func_t f, int m);
    add_item(f, m, $urandom_range(0, 1023), $urandom_range(0, 1), $urandom_range(0, 1),
             $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1023));
  endfunction

  function automatic int clip_pwm(int v);
    return (v < 0) ? 0 : ((v > 1023) ? 1023 : v);
  endfunction

  function automatic void gen_monitor(int m, int fpct);
    int p, sel, sb, db;
    sel = $urandom_range(0, 9);
    if (m < MOTORS && sel < 4)
      p = clip_pwm(gen_thr[m] + $urandom_range(0, 6) - 3);
    else if (m < MOTORS && sel < 6)
      p = clip_pwm(gen_base[m] + mcfg.base_delta + $urandom_range(0, 6) - 3);
    else
      p = $urandom_range(0, 1023);
    sb = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : 0;
    db = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : ($urandom_range(0, 255) & 8'hBF);
    if ($urandom_range(0, 99) < fpct) db = db | OVERCURRENT_BIT;
    add_item(FUNC_MONITOR, m, p, $urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0, sb, db,
             $urandom_range(0, 1023));
  endfunction

  task automatic gen_moves(int n);
    int target, k, cnt, t, fpct, ma, mb, sel;
    target = gen_cnt + n;
    while (gen_cnt < target) begin
      if ($urandom_range(0, 9) != 0) add_rand(FUNC_START, $urandom_range(0, 7));
      cnt = $urandom_range(0, 3);
      for (k = 0; k < cnt; k++) begin
        case ($urandom_range(0, 5))
          0:       t = 0;
          1:       t = 1023;
          2:       t = $urandom_range(1, 1023);
          default: t = $urandom_range(100, 600);
        endcase
        add_item(FUNC_THRESHOLD, $urandom_range(0, 7), $urandom_range(0, 1023),
                 $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 255),
                 $urandom_range(0, 255), t);
      end
      if ($urandom_range(0, 3) != 0) begin
        cnt = $urandom_range(1, 3);
        for (k = 0; k < cnt; k++)
          add_item(FUNC_BASELINE, $urandom_range(0, 7), $urandom_range(0, 400),
                   $urandom_range(0, 9) != 0, $urandom_range(0, 1), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 1023));
      end
      case ($urandom_range(0, 2))
        0:       fpct = 5;
        1:       fpct = 30;
        default: fpct = 80;
      endcase
      ma  = $urandom_range(0, MOTORS - 1);
      mb  = (mcfg.base_motor < MOTORS) ? mcfg.base_motor : ma;
      cnt = $urandom_range(8, 40);
      for (k = 0; k < cnt; k++) begin
        sel = $urandom_range(0, 19);
        if ($urandom_range(0, 11) == 0)
          add_rand(func_t'($urandom_range(0, 3)), $urandom_range(0, 7));
        else if (sel < 9)
          gen_monitor(ma, fpct);
        else if (sel < 16)
          gen_monitor(mb, fpct);
        else if (sel < 19)
          gen_monitor($urandom_range(0, MOTORS - 1), fpct);
        else
          gen_monitor($urandom_range(MOTORS, 7), fpct);
      end
    end
  endtask

  task automatic write_reg(cfg_reg_t r, int v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v[CFG_DAT_W-1:0];
    case (r)
      REG_BASE_DELTA:        mcfg.base_delta        = v[PWM_W-1:0];
      REG_BASE_HITS_NEEDED:  mcfg.base_hits_needed  = v[7:0];
      REG_OTHER_HITS_NEEDED: mcfg.other_hits_needed = v[7:0];
      REG_DEMO_MODE:         mcfg.demo_mode         = v[0];
      REG_BASE_MOTOR:        mcfg.base_motor        = v[2:0];
      REG_STATUS_CHECK_ON:   mcfg.status_check_on   = v[0];
      REG_STATUS_FAULT_MASK: mcfg.status_fault_mask = v[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_regs(int d, int bh, int oh, int dm, int bm, int sc, int mk);
    write_reg(REG_BASE_DELTA, d);
    write_reg(REG_BASE_HITS_NEEDED, bh);
    write_reg(REG_OTHER_HITS_NEEDED, oh);
    write_reg(REG_DEMO_MODE, dm);
    write_reg(REG_BASE_MOTOR, bm);
    write_reg(REG_STATUS_CHECK_ON, sc);
    write_reg(REG_STATUS_FAULT_MASK, mk);
  endtask

  task automatic wait_idle();
    while (pend_q.size() != 0 || exp_q.size() != 0 || in_tvalid) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Item driver.
  always @(negedge clk) begin
    if (in_taken || !in_tvalid) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        drv_item = pend_q.pop_front();
        in_tdata <= {7'd0, drv_item.threshold_value, drv_item.detail_bits,
                     drv_item.status_bits, drv_item.status_ok, drv_item.read_ok,
                     drv_item.pwm, drv_item.motor};
        in_tuser  <= drv_item.func;
        in_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 80);
      end
      rx_left--;
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // Result checker and prediction of accepted items.
  always @(posedge clk) begin
    result_t want;
    in_taken = rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result item: tdata=%h", out_tdata);
      end else begin
        want = exp_q.pop_front();
        if (out_tdata[0] !== want.tripped || out_tdata[1] !== want.trip_now ||
            out_tdata[3:2] !== want.trip_cause || out_tdata[6:4] !== want.trip_motor ||
            out_tdata[7] !== want.pwm_high || out_tdata[8] !== want.status_fault ||
            out_tdata[18:9] !== want.peak_pwm) begin
          fails++;
          if (fails <= 10) begin
            $display("result mismatch, expected: tripped=%0d now=%0d cause=%0d motor=%0d",
                     want.tripped, want.trip_now, want.trip_cause, want.trip_motor,
                     " high=%0d fault=%0d peak=%0d",
                     want.pwm_high, want.status_fault, want.peak_pwm);
            $display("result mismatch, actual:   tripped=%0d now=%0d cause=%0d motor=%0d",
                     out_tdata[0], out_tdata[1], out_tdata[3:2], out_tdata[6:4],
                     " high=%0d fault=%0d peak=%0d",
                     out_tdata[7], out_tdata[8], out_tdata[18:9]);
          end
        end
      end
    end
    if (in_taken) exp_q.push_back(predict_result(drv_item));
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("multi_motor_overload_monitor_unit verification failed");
      $finish;
    end
  end

  initial begin
    int k, ph;
    mcfg.base_delta        = '0;
    mcfg.base_hits_needed  = 8'd3;
    mcfg.other_hits_needed = 8'd3;
    mcfg.demo_mode         = 1'b0;
    mcfg.base_motor        = '0;
    mcfg.status_check_on   = 1'b1;
    mcfg.status_fault_mask = 8'h50;
    for (k = 0; k < MOTORS; k++) thr_tab[k] = '0;
    clear_move_state();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed items under the reset settings.
    add_item(FUNC_MONITOR,   0, 1023, 1, 1, 8'h00, 8'h00, 0);
    add_item(FUNC_THRESHOLD, 0, 0, 0, 0, 8'h00, 8'h00, 1023);
    add_item(FUNC_THRESHOLD, 1, 0, 0, 0, 8'h00, 8'h00, 1);
    add_item(FUNC_THRESHOLD, 5, 0, 0, 0, 8'h00, 8'h00, 500);
    add_item(FUNC_THRESHOLD, 7, 0, 0, 0, 8'h00, 8'h00, 100);
    add_item(FUNC_BASELINE,  0, 0, 1, 1, 8'h00, 8'h00, 0);
    add_item(FUNC_BASELINE,  6, 55, 1, 1, 8'h00, 8'h00, 0);
    add_item(FUNC_BASELINE,  1, 300, 0, 1, 8'h00, 8'h00, 0);
    for (k = 0; k < 3; k++) add_item(FUNC_MONITOR, 1, 2, 1, 1, 8'h00, 8'hBF, 0);
    add_item(FUNC_MONITOR,   5, 1023, 1, 1, 8'hFF, 8'h00, 0);
    add_item(FUNC_THRESHOLD, 1, 0, 0, 0, 8'h00, 8'h00, 0);
    add_item(FUNC_START,     7, 1023, 1, 1, 8'hFF, 8'hFF, 1023);
    add_item(FUNC_MONITOR,   2, 0, 1, 1, 8'h10, 8'h00, 0);
    add_item(FUNC_MONITOR,   2, 0, 1, 1, 8'h00, 8'h40, 0);
    add_item(FUNC_MONITOR,   2, 0, 1, 1, 8'h40, 8'h00, 0);
    add_item(FUNC_START,     0, 0, 0, 0, 8'h00, 8'h00, 0);
    add_item(FUNC_MONITOR,   3, 700, 1, 0, 8'hFF, 8'hFF, 0);
    add_item(FUNC_MONITOR,   6, 900, 1, 1, 8'hFF, 8'h00, 0);
    add_item(FUNC_MONITOR,   5, 1023, 0, 1, 8'h00, 8'h00, 0);
    add_item(FUNC_MONITOR,   0, 1023, 1, 1, 8'h00, 8'h00, 0);
    add_item(FUNC_MONITOR,   4, 0, 1, 1, 8'hAF, 8'h00, 0);
    add_item(FUNC_START,     3, 0, 0, 0, 8'h00, 8'h00, 0);
    wait_idle();

    // Long run of faults on the base motor up to the largest hit counts.
    set_regs(0, 255, 254, 0, 0, 1, 8'h50);
    add_rand(FUNC_START, 0);
    add_item(FUNC_THRESHOLD, 0, 0, 0, 0, 8'h00, 8'h00, 10);
    for (k = 0; k < 262; k++)
      add_item(FUNC_MONITOR, 0, $urandom_range(0, 1023), $urandom_range(0, 1), 1,
               $urandom_range(0, 255), $urandom_range(0, 255) | 8'h40, $urandom_range(0, 1023));
    add_rand(FUNC_START, 0);
    wait_idle();

    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_regs(0, 0, 0, 1, 0, 1, 8'hFF);
        1: set_regs(1023, 1, 2, 1, 3, 0, 8'h00);
        2: set_regs($urandom_range(0, 1023), $urandom_range(1, 4), $urandom_range(1, 4), 1, 7, 1,
                    $urandom_range(0, 255));
        3: set_regs($urandom_range(0, 40), 2, 3, 1, 5, 1, 8'h50);
        4: set_regs($urandom_range(0, 1023), 3, 3, 0, 6, 1, $urandom_range(0, 255));
        default: set_regs($urandom_range(0, 1023), $urandom_range(0, 5), $urandom_range(0, 5),
                          $urandom_range(0, 1), $urandom_range(0, 7), $urandom_range(0, 1),
                          $urandom_range(0, 255));
      endcase
      gen_moves(95);
      if (ph == 3) hold_req++;
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (exp_q.size() != 0) fails++;
    if (fails == 0) begin
      $display("multi_motor_overload_monitor_unit verification clean");
    end else begin
      $display("multi_motor_overload_monitor_unit verification failed");
    end
    $finish;
  end

endmodule
